// ===== rtl/ffha_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg : shared types and constants of the first-fit heap allocator
// Item kinds, status codes, controller states and the command/status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int POOL_BYTES_DEF = 4096;
    localparam int HEADER_BYTES   = 4;
    // Walk offset width: covers the last header plus header and any 16-bit size
    localparam int WALK_W         = 18;

    typedef enum logic [1:0] {
        KIND_INIT  = 2'd0,
        KIND_ALLOC = 2'd1,
        KIND_FREE  = 2'd2,
        KIND_STAT  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_ZERO   = 2'd1,
        STAT_NOFIT  = 2'd2,
        STAT_BADPTR = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_RD,
        S_EVAL,
        S_SPLIT,
        S_MARK,
        S_FREE_RD,
        S_FREE_WR,
        S_FINISH
    } fsm_state_t;

    typedef struct packed {
        logic    take;
        logic    wr_init;
        logic    rd_walk;
        logic    rd_free;
        logic    step;
        logic    wr_split;
        logic    wr_mark;
        logic    grant;
        logic    wr_free;
        logic    set_code;
        status_t code;
        logic    load_out;
    } ffha_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  req_zero;
        logic  null_ptr;
        logic  ptr_bad;
        logic  walk_end;
        logic  fits;
        logic  do_split;
        logic  nx_ok;
        logic  out_free;
    } ffha_sts_t;

endpackage

// ===== rtl/ffha_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_ram : generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/ffha_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_ctrl : allocator sequencer
// Steps each item through header reads, splits, flag updates and the
// hand-off of its result to the output register.
// ----------------------------------------------------------------------------
module ffha_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ffha_pkg::ffha_sts_t sts,
    output ffha_pkg::ffha_cmd_t cmd
);
    import ffha_pkg::*;

    fsm_state_t state_reg;
    fsm_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.code   = STAT_OK;
        unique case (state_reg)
            S_INIT: begin
                // rebuild the single free block after reset
                cmd.wr_init = 1'b1;
                state_next  = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.take   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (sts.kind)
                    KIND_INIT: begin
                        cmd.wr_init = 1'b1;
                        state_next  = S_FINISH;
                    end
                    KIND_ALLOC: begin
                        if (sts.req_zero) begin
                            cmd.set_code = 1'b1;
                            cmd.code     = STAT_ZERO;
                            state_next   = S_FINISH;
                        end else begin
                            state_next = S_RD;
                        end
                    end
                    KIND_FREE: begin
                        if (sts.null_ptr) begin
                            state_next = S_FINISH;
                        end else if (sts.ptr_bad) begin
                            cmd.set_code = 1'b1;
                            cmd.code     = STAT_BADPTR;
                            state_next   = S_FINISH;
                        end else begin
                            state_next = S_FREE_RD;
                        end
                    end
                    KIND_STAT: begin
                        state_next = S_RD;
                    end
                endcase
            end
            S_RD: begin
                if (sts.walk_end) begin
                    if (sts.kind == KIND_ALLOC) begin
                        cmd.set_code = 1'b1;
                        cmd.code     = STAT_NOFIT;
                    end
                    state_next = S_FINISH;
                end else begin
                    cmd.rd_walk = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL: begin
                if (sts.kind == KIND_ALLOC && sts.fits) begin
                    state_next = (sts.do_split && sts.nx_ok) ? S_SPLIT : S_MARK;
                end else begin
                    cmd.step   = 1'b1;
                    state_next = S_RD;
                end
            end
            S_SPLIT: begin
                cmd.wr_split = 1'b1;
                state_next   = S_MARK;
            end
            S_MARK: begin
                cmd.wr_mark = 1'b1;
                cmd.grant   = 1'b1;
                state_next  = S_FINISH;
            end
            S_FREE_RD: begin
                cmd.rd_free = 1'b1;
                state_next  = S_FREE_WR;
            end
            S_FREE_WR: begin
                cmd.wr_free = 1'b1;
                state_next  = S_FINISH;
            end
            S_FINISH: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule

// ===== rtl/ffha_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_dp : allocator datapath
// Header store, walk offset, usage sums, result and output registers.
// ----------------------------------------------------------------------------
module ffha_dp #(
    parameter int POOL_BYTES = ffha_pkg::POOL_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ffha_pkg::ffha_cmd_t cmd,
    output ffha_pkg::ffha_sts_t sts,
    input  logic [1:0]          s_kind,
    input  logic [15:0]         s_request_bytes,
    input  logic [15:0]         s_payload_offset,
    input  logic                s_null_pointer,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_status,
    output logic [15:0]         m_granted_offset,
    output logic [15:0]         m_used_bytes,
    output logic [15:0]         m_free_bytes
);
    import ffha_pkg::*;

    localparam int                AW        = $clog2(POOL_BYTES);
    localparam logic [WALK_W-1:0] POOL_W    = WALK_W'(POOL_BYTES);
    localparam logic [WALK_W-1:0] HDR_W     = WALK_W'(HEADER_BYTES);
    localparam logic [16:0]       POOL_17   = 17'(POOL_BYTES);
    localparam logic [16:0]       HDR_17    = 17'(HEADER_BYTES);
    localparam logic [15:0]       HDR_16    = 16'(HEADER_BYTES);
    localparam logic [15:0]       INIT_SIZE = 16'(POOL_BYTES - HEADER_BYTES);

    kind_t             kind_reg;
    logic [15:0]       req_reg;
    logic [15:0]       ptr_reg;
    logic              null_reg;
    logic [WALK_W-1:0] walk_reg;
    logic [15:0]       used_sum_reg;
    logic [15:0]       free_sum_reg;
    status_t           res_status_reg;
    logic [15:0]       res_granted_reg;
    logic              m_valid_reg;
    logic [1:0]        m_status_reg;
    logic [15:0]       m_granted_reg;
    logic [15:0]       m_used_reg;
    logic [15:0]       m_free_reg;

    logic [16:0]       rdata;
    logic              hdr_used;
    logic [15:0]       hdr_size;
    logic [WALK_W-1:0] step_off;
    logic [WALK_W-1:0] nx_off;
    logic [16:0]       req_plus_hdr;
    logic [16:0]       ptr_hdr;
    logic              split_w;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [16:0]       wdata;
    logic              re;
    logic [AW-1:0]     raddr;

    assign hdr_used     = rdata[16];
    assign hdr_size     = rdata[15:0];
    assign step_off     = walk_reg + HDR_W + WALK_W'(hdr_size);
    assign nx_off       = walk_reg + HDR_W + WALK_W'(req_reg);
    assign req_plus_hdr = {1'b0, req_reg} + HDR_17;
    assign ptr_hdr      = {1'b0, ptr_reg} - HDR_17;
    assign split_w      = {1'b0, hdr_size} > req_plus_hdr;

    assign sts.kind     = kind_reg;
    assign sts.req_zero = (req_reg == 16'd0);
    assign sts.null_ptr = null_reg;
    assign sts.ptr_bad  = (ptr_reg < HDR_16) || (ptr_hdr >= POOL_17);
    assign sts.walk_end = (walk_reg >= POOL_W);
    assign sts.fits     = !hdr_used && (hdr_size >= req_reg);
    assign sts.do_split = split_w;
    assign sts.nx_ok    = (nx_off < POOL_W);
    assign sts.out_free = !m_valid_reg || m_ready;

    // write port: one source per cycle
    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        priority if (cmd.wr_init) begin
            we    = 1'b1;
            wdata = {1'b0, INIT_SIZE};
        end else if (cmd.wr_split) begin
            we    = 1'b1;
            waddr = nx_off[AW-1:0];
            wdata = {1'b0, hdr_size - req_reg - HDR_16};
        end else if (cmd.wr_mark) begin
            we    = 1'b1;
            waddr = walk_reg[AW-1:0];
            wdata = {1'b1, split_w ? req_reg : hdr_size};
        end else if (cmd.wr_free) begin
            we    = 1'b1;
            waddr = ptr_hdr[AW-1:0];
            wdata = {1'b0, hdr_size};
        end else begin
            we = 1'b0;
        end
    end

    assign re    = cmd.rd_walk || cmd.rd_free;
    assign raddr = cmd.rd_free ? ptr_hdr[AW-1:0] : walk_reg[AW-1:0];

    ffha_ram #(
        .WIDTH (17),
        .DEPTH (POOL_BYTES)
    ) u_hdr_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            kind_reg        <= kind_t'(s_kind);
            req_reg         <= s_request_bytes;
            ptr_reg         <= s_payload_offset;
            null_reg        <= s_null_pointer;
            walk_reg        <= '0;
            used_sum_reg    <= '0;
            free_sum_reg    <= '0;
            res_status_reg  <= STAT_OK;
            res_granted_reg <= '0;
        end else begin
            if (cmd.step) begin
                walk_reg <= step_off;
                if (kind_reg == KIND_STAT) begin
                    if (hdr_used) begin
                        used_sum_reg <= used_sum_reg + hdr_size;
                    end else begin
                        free_sum_reg <= free_sum_reg + hdr_size;
                    end
                end
            end
            if (cmd.set_code) begin
                res_status_reg <= cmd.code;
            end
            if (cmd.grant) begin
                res_granted_reg <= 16'(walk_reg + HDR_W);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_status_reg  <= res_status_reg;
            m_granted_reg <= res_granted_reg;
            m_used_reg    <= used_sum_reg;
            m_free_reg    <= free_sum_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_granted_offset = m_granted_reg;
    assign m_used_bytes     = m_used_reg;
    assign m_free_bytes     = m_free_reg;

endmodule

// ===== rtl/first_fit_heap_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator : first-fit pool allocator with block headers
//
// Input channel (s_valid/s_ready) carries one command per transfer: reinit,
// allocate, free or usage report. Result channel (m_valid/m_ready) returns
// exactly one result per command, in order.
// One command is processed at a time; s_ready is high only while idle.
// Steps, accept to result valid (receiver ready):
//   reinit, zero-size alloc, null/bad free : dispatch, finish
//   free : dispatch, header read, header write, finish
//   usage / failed allocate : dispatch, a read and an evaluate per header
//   walked, finish; granted allocate : that walk, taken header included,
//   then split (only when the block is split), mark, finish. Each header costs
//   a RAM read and an evaluate step, so the chain length sets throughput.
// s_ready comes back the cycle after the result is loaded.
// After aresetn the header RAM gets one write, in S_INIT, that rebuilds the
// single free block; s_ready rises on the following cycle.
// A finished result sits in the output register; the next command is taken
// while it waits, and only the hand-off of that command's result stalls
// until the receiver takes the pending one.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
    parameter int POOL_BYTES = ffha_pkg::POOL_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [15:0] s_request_bytes,
    input  logic [15:0] s_payload_offset,
    input  logic        s_null_pointer,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [15:0] m_granted_offset,
    output logic [15:0] m_used_bytes,
    output logic [15:0] m_free_bytes
);
    import ffha_pkg::*;

    // controller <-> datapath bundles
    ffha_cmd_t cmd;
    ffha_sts_t sts;

    // sequencer: walks, splits, flag writes, result hand-off
    ffha_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // header RAM, walk offset, sums, result and output registers
    ffha_dp #(
        .POOL_BYTES (POOL_BYTES)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .s_kind           (s_kind),
        .s_request_bytes  (s_request_bytes),
        .s_payload_offset (s_payload_offset),
        .s_null_pointer   (s_null_pointer),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_granted_offset (m_granted_offset),
        .m_used_bytes     (m_used_bytes),
        .m_free_bytes     (m_free_bytes)
    );

endmodule

// ===== rtl/ffha_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_checker : port-level checks of the allocator
// Watches both channels and flags result fields that cannot go together.
// ----------------------------------------------------------------------------
module ffha_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [15:0] m_granted_offset,
    input logic [15:0] m_used_bytes,
    input logic [15:0] m_free_bytes
);
    import ffha_pkg::*;

    // one command at a time: busy right after a transfer in
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ffha: s_ready high right after input transfer");

    // a stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_granted_offset))
        else $error("ffha: stalled result changed");

    // failed commands carry no grant and no usage totals
    a_fail_no_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STAT_OK |-> m_granted_offset == 16'd0
            && m_used_bytes == 16'd0 && m_free_bytes == 16'd0)
        else $error("ffha: failed command carries data");

    // usage totals and a grant never come in the same result
    a_stat_no_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_used_bytes != 16'd0 || m_free_bytes != 16'd0)
            |-> m_granted_offset == 16'd0)
        else $error("ffha: usage result carries a grant");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_status         (m_status),
    .m_granted_offset (m_granted_offset),
    .m_used_bytes     (m_used_bytes),
    .m_free_bytes     (m_free_bytes)
);
